### rtl/lscd_pkg.sv
// shared types and constants for the sector cache directory
package lscd_pkg;

  localparam int unsigned SLOTS_DEF = 256;
  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_GET        = 3'd0,
    FN_PUT        = 3'd1,
    FN_WB_DONE    = 3'd2,
    FN_FILL_DONE  = 3'd3,
    FN_RELEASE    = 3'd4,
    FN_NEXT_DIRTY = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FILL    = 3'd1,
    ST_WB      = 3'd2,
    ST_BUSY    = 3'd3,
    ST_BADADDR = 3'd4,
    ST_NONE    = 3'd5,
    ST_IOERR   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  device_id;
    logic [47:0] block_address;
    logic [47:0] sector_limit;
    logic [7:0]  slot;
    logic        mark_dirty;
    logic        io_ok;
    logic        all_devices;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_slot;
    logic [3:0]  victim_device;
    logic [47:0] victim_address;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [15:0] pin;
    logic [3:0]  dev;
    logic [47:0] addr;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
    logic idx_max;
  } ctl_sts_t;

endpackage

### rtl/lscd_ctrl.sv
// controller state machine: clearing pass, slot scan and result sequencing
module lscd_ctrl
  import lscd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.idx_max) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (sts_i.last) begin
          state_d = S_WAIT;
        end
      end
      // last read data is being looked at
      S_WAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_IDLE))
    else $error("finish not followed by idle");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !sts_i.idx_max) |=> (state_q == S_CLEAR))
    else $error("clearing pass left early");

endmodule

### rtl/lscd_dpath.sv
// datapath: slot memory, scan index, victim trackers and result register
module lscd_dpath
  import lscd_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctl_cmd_t cmd_i,
  output ctl_sts_t sts_o,
  input  req_t     req_i,
  output logic     done_o,
  output rsp_t     rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] IDX_MAX = IW'(SLOTS - 1);

  entry_t mem [SLOTS];

  req_t          req_q;
  logic          single_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] p_idx_q;
  logic          dv_q;
  entry_t        rd_q;
  logic [63:0]   cnt_q;

  logic          hit_f_q, free_f_q, clean_f_q, dirty_f_q, busy_f_q, nd_f_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, clean_idx_q, dirty_idx_q, nd_idx_q;
  entry_t        hit_e_q, dirty_e_q, nd_e_q, sel_e_q;
  logic [63:0]   clean_stamp_q;

  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;

  logic          fin_we;
  logic [IW-1:0] fin_idx;
  entry_t        fin_e;
  logic          bump;
  rsp_t          fin_rsp;

  logic          tag_hit, dev_ok, in_range, rel_wr, load_single;
  logic [63:0]   stamp_next;

  assign stamp_next  = cnt_q + 64'd1;
  assign in_range    = ({24'd0, req_q.slot} < 32'(SLOTS));
  assign load_single = (req_i.func != FN_GET) && (req_i.func != FN_RELEASE) &&
                       (req_i.func != FN_NEXT_DIRTY);
  assign tag_hit     = rd_q.valid && (rd_q.dev == req_q.device_id) &&
                       (rd_q.addr == req_q.block_address);
  assign dev_ok      = req_q.all_devices || (rd_q.dev == req_q.device_id);
  assign rel_wr      = dv_q && (req_q.func == FN_RELEASE) && rd_q.valid && dev_ok &&
                       (rd_q.pin == 16'd0);

  assign sts_o.last    = single_q || (idx_q == IDX_MAX);
  assign sts_o.idx_max = (idx_q == IDX_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      dv_q     <= 1'b0;
      single_q <= 1'b0;
      cnt_q    <= '0;
      done_o   <= 1'b0;
    end else begin
      dv_q   <= cmd_i.read;
      done_o <= cmd_i.finish;
      if (cmd_i.load) begin
        single_q <= load_single;
        idx_q    <= load_single ? IW'(req_i.slot) : '0;
      end else if (cmd_i.clear || cmd_i.read) begin
        idx_q <= idx_q + 1'b1;
      end
      if (bump && cmd_i.finish) begin
        cnt_q <= stamp_next;
      end
    end
  end

  // tracker flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_f_q   <= 1'b0;
      free_f_q  <= 1'b0;
      clean_f_q <= 1'b0;
      dirty_f_q <= 1'b0;
      busy_f_q  <= 1'b0;
      nd_f_q    <= 1'b0;
    end else if (cmd_i.load) begin
      hit_f_q   <= 1'b0;
      free_f_q  <= 1'b0;
      clean_f_q <= 1'b0;
      dirty_f_q <= 1'b0;
      busy_f_q  <= 1'b0;
      nd_f_q    <= 1'b0;
    end else if (dv_q) begin
      case (req_q.func)
        FN_GET: begin
          if (tag_hit) begin
            hit_f_q <= 1'b1;
          end
          if (rd_q.pin == 16'd0) begin
            if (!rd_q.valid) begin
              free_f_q <= 1'b1;
            end else if (rd_q.dirty) begin
              dirty_f_q <= 1'b1;
            end else begin
              clean_f_q <= 1'b1;
            end
          end
        end
        FN_RELEASE: begin
          if (rd_q.valid && dev_ok && rd_q.pin != 16'd0) begin
            busy_f_q <= 1'b1;
          end
        end
        FN_NEXT_DIRTY: begin
          if (rd_q.valid && rd_q.dirty && dev_ok) begin
            nd_f_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tracker payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (dv_q) begin
      sel_e_q <= rd_q;
      if (tag_hit && !hit_f_q) begin
        hit_idx_q <= p_idx_q;
        hit_e_q   <= rd_q;
      end
      if (rd_q.pin == 16'd0) begin
        if (!rd_q.valid) begin
          if (!free_f_q) begin
            free_idx_q <= p_idx_q;
          end
        end else if (rd_q.dirty) begin
          if (!dirty_f_q || rd_q.stamp < dirty_e_q.stamp) begin
            dirty_idx_q <= p_idx_q;
            dirty_e_q   <= rd_q;
          end
        end else if (!clean_f_q || rd_q.stamp < clean_stamp_q) begin
          clean_idx_q   <= p_idx_q;
          clean_stamp_q <= rd_q.stamp;
        end
      end
      if (rd_q.valid && rd_q.dirty && dev_ok && !nd_f_q) begin
        nd_idx_q <= p_idx_q;
        nd_e_q   <= rd_q;
      end
    end
    if (cmd_i.finish) begin
      rsp_o <= fin_rsp;
    end
  end

  // final decision and write-back of the touched slot
  always_comb begin
    fin_we  = 1'b0;
    fin_idx = IW'(req_q.slot);
    fin_e   = sel_e_q;
    bump    = 1'b0;
    fin_rsp = '0;
    fin_rsp.status = ST_NONE;
    case (req_q.func)
      FN_GET: begin
        if (!(req_q.block_address < req_q.sector_limit)) begin
          fin_rsp.status = ST_BADADDR;
        end else if (hit_f_q) begin
          fin_idx     = hit_idx_q;
          fin_e       = hit_e_q;
          fin_e.pin   = (hit_e_q.pin < PIN_MAX) ? hit_e_q.pin + 16'd1 : hit_e_q.pin;
          fin_e.stamp = stamp_next;
          fin_we      = 1'b1;
          bump        = 1'b1;
          fin_rsp.status      = ST_OK;
          fin_rsp.result_slot = 8'(hit_idx_q);
        end else if (free_f_q || clean_f_q) begin
          fin_idx     = free_f_q ? free_idx_q : clean_idx_q;
          fin_e.valid = 1'b1;
          fin_e.dirty = 1'b0;
          fin_e.pin   = 16'd1;
          fin_e.dev   = req_q.device_id;
          fin_e.addr  = req_q.block_address;
          fin_e.stamp = stamp_next;
          fin_we      = 1'b1;
          bump        = 1'b1;
          fin_rsp.status      = ST_FILL;
          fin_rsp.result_slot = 8'(fin_idx);
        end else if (dirty_f_q) begin
          fin_rsp.status         = ST_WB;
          fin_rsp.result_slot    = 8'(dirty_idx_q);
          fin_rsp.victim_device  = dirty_e_q.dev;
          fin_rsp.victim_address = dirty_e_q.addr;
        end else begin
          fin_rsp.status = ST_BUSY;
        end
      end
      FN_PUT: begin
        if (in_range) begin
          fin_e.dirty = sel_e_q.dirty | req_q.mark_dirty;
          fin_e.pin   = (sel_e_q.pin != 16'd0) ? sel_e_q.pin - 16'd1 : 16'd0;
          fin_e.stamp = stamp_next;
          fin_we      = 1'b1;
          bump        = 1'b1;
          fin_rsp.status      = ST_OK;
          fin_rsp.result_slot = req_q.slot;
        end
      end
      FN_WB_DONE: begin
        if (in_range) begin
          fin_rsp.result_slot = req_q.slot;
          if (req_q.io_ok) begin
            fin_e.dirty    = 1'b0;
            fin_we         = 1'b1;
            fin_rsp.status = ST_OK;
          end else begin
            fin_rsp.status = ST_IOERR;
          end
        end
      end
      FN_FILL_DONE: begin
        if (in_range) begin
          fin_rsp.result_slot = req_q.slot;
          if (req_q.io_ok) begin
            fin_rsp.status = ST_OK;
          end else begin
            fin_e.valid    = 1'b0;
            fin_e.pin      = 16'd0;
            fin_we         = 1'b1;
            fin_rsp.status = ST_IOERR;
          end
        end
      end
      FN_RELEASE: begin
        fin_rsp.status = busy_f_q ? ST_BUSY : ST_OK;
      end
      FN_NEXT_DIRTY: begin
        if (nd_f_q) begin
          fin_rsp.status         = ST_WB;
          fin_rsp.result_slot    = 8'(nd_idx_q);
          fin_rsp.victim_device  = nd_e_q.dev;
          fin_rsp.victim_address = nd_e_q.addr;
        end
      end
      default: begin
      end
    endcase
  end

  // single write port: clearing pass, release drops, final update
  always_comb begin
    we = 1'b0;
    wa = idx_q;
    wd = '0;
    if (cmd_i.clear) begin
      we = 1'b1;
    end else if (rel_wr) begin
      we       = 1'b1;
      wa       = p_idx_q;
      wd       = rd_q;
      wd.valid = 1'b0;
      wd.dirty = 1'b0;
    end else if (cmd_i.finish) begin
      we = fin_we;
      wa = fin_idx;
      wd = fin_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q    <= mem[idx_q];
    p_idx_q <= idx_q;
  end

endmodule

### rtl/lru_sector_cache_directory.sv
// top level of the lru sector cache directory
//
//  port group      dir  handshake            contents
//  start_i/req_i   in   start_i & !busy_o    one directory command
//  done_o/rsp_o    out  done_o, one cycle    status, slot and victim tags
//
// get, release and next dirty scan every slot once from the slot memory.
// put, writeback done and fill done read one slot and rewrite it where the outcome needs it.
// after reset a clearing pass writes every slot while busy_o is high.
// busy_o drops in the cycle the result is shown; the receiver cannot stall.
module lru_sector_cache_directory
  import lscd_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lscd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  lscd_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
